// ===== rtl/core/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types, constants and helpers for the keepalive timeout table.
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PADDR_W     = 3;
    localparam int TICKS_W     = 8;

    localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 8'd10;
    localparam logic [TICKS_W-1:0] TICKS_MAX     = 8'hFF;

    // register index (paddr word address)
    localparam logic [PADDR_W-3:0] REG_TIMEOUT = 1'b0;

    // commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_EXPIRED   = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] link_key;
        logic [7:0]  elem_type;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [7:0]  out_elem_type;
        logic [31:0] out_addr;
        logic [15:0] out_port;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  etype;
        logic [31:0] addr;
        logic [15:0] port;
    } t_info;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             info_we;
        logic             ticks_we;
        logic [IDX_W-1:0] wr_addr;
    } t_store_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    function automatic t_out_item make_status(input logic [2:0] status,
                                              input logic [31:0] key);
        t_out_item r;
        r               = '0;
        r.status        = status;
        r.out_key       = key;
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/kat_entry_store.sv =====
// ----------------------------------------------------------------------------
// kat_entry_store
// Entry storage: link info memory and tick count memory, one read port and
// one write port each, read data registered.
// ----------------------------------------------------------------------------
module kat_entry_store
    import kat_pkg::*;
(
    input  logic               i_clk,
    input  t_store_ctl         i_ctl,
    input  t_info              i_wr_info,
    input  logic [TICKS_W-1:0] i_wr_ticks,
    output t_info              o_rd_info,
    output logic [TICKS_W-1:0] o_rd_ticks
);

    t_info              r_info_mem  [TABLE_DEPTH];
    logic [TICKS_W-1:0] r_ticks_mem [TABLE_DEPTH];
    t_info              r_rd_info;
    logic [TICKS_W-1:0] r_rd_ticks;

    always_ff @(posedge i_clk) begin
        if (i_ctl.info_we) begin
            r_info_mem[i_ctl.wr_addr] <= i_wr_info;
        end
        if (i_ctl.rd_en) begin
            r_rd_info <= r_info_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ticks_we) begin
            r_ticks_mem[i_ctl.wr_addr] <= i_wr_ticks;
        end
        if (i_ctl.rd_en) begin
            r_rd_ticks <= r_ticks_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_info  = r_rd_info;
    assign o_rd_ticks = r_rd_ticks;

endmodule

// ===== rtl/core/keepalive_timeout_table_core.sv =====
// ----------------------------------------------------------------------------
// keepalive_timeout_table_core
// Aging table of watched links: add/refresh, remove and tick expiry.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/i_in_data and are taken when o_in_stall is low.
// Results leave on o_out_valid/o_out_data and are taken when i_out_stall is
// low; last marks the final result of a request.
// Each request walks all table slots, one per cycle unless the scan pauses,
// through the entry memory (read into registered read data, then modify and
// write back), passing through the states idle (accept), scan and finish. The
// first result of an add or remove appears on the cycle after finish.
// Expiries on a tick are held one deep, so each is issued when the next one
// is found or at the end of the scan.
// o_in_stall is high while a request is in progress. A stalled output holds
// its result; the scan pauses when a further expiry meets a full output.
// Command 3 is accepted and dropped with no result.
// timeout_ticks is set through the APB port at address 0, reset value 10.
// Reset clears all slot valid bits and the control state; no clearing pass.
// ----------------------------------------------------------------------------
module keepalive_timeout_table_core
    import kat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state                  r_state, n_state;
    t_in_item                r_req, n_req;
    logic [IDX_W-1:0]        r_pidx, n_pidx;
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_fidx, n_fidx;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic                    r_pend, n_pend;
    t_out_item               r_pend_res, n_pend_res;
    logic [TABLE_DEPTH-1:0]  r_valid, n_valid;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;
    logic [TICKS_W-1:0]      r_timeout;

    t_store_ctl              st_ctl;
    t_info                   wr_info;
    logic [TICKS_W-1:0]      wr_ticks;
    t_info                   rd_info;
    logic [TICKS_W-1:0]      rd_ticks;

    logic                    out_free;
    logic                    cur_valid;
    logic                    expire;
    logic                    key_hit;
    logic                    hold;
    logic                    emit;
    t_out_item               emit_res;

    kat_entry_store u_store (
        .i_clk      (i_clk),
        .i_ctl      (st_ctl),
        .i_wr_info  (wr_info),
        .i_wr_ticks (wr_ticks),
        .o_rd_info  (rd_info),
        .o_rd_ticks (rd_ticks)
    );

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT) ? {24'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[PADDR_W-1:2] == REG_TIMEOUT) begin
            r_timeout <= pwdata[TICKS_W-1:0];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign cur_valid = r_valid[r_pidx];
    assign expire    = (rd_ticks >= r_timeout);
    assign key_hit   = cur_valid && (rd_info.key == r_req.link_key);
    assign hold      = (r_req.command == CMD_TICK) && cur_valid && expire &&
                       r_pend && !out_free;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_pidx       = r_pidx;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_pend       = r_pend;
        n_pend_res   = r_pend_res;
        n_valid      = r_valid;
        st_ctl       = '0;
        wr_info      = '{key: r_req.link_key, etype: r_req.elem_type,
                         addr: r_req.peer_addr, port: r_req.peer_port};
        wr_ticks     = '0;
        emit         = 1'b0;
        emit_res     = r_pend_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_data.command != CMD_NONE) begin
                    n_req          = i_in_data;
                    n_found        = 1'b0;
                    n_free_found   = 1'b0;
                    n_pend         = 1'b0;
                    n_pidx         = '0;
                    st_ctl.rd_en   = 1'b1;
                    st_ctl.rd_addr = '0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!hold) begin
                    case (r_req.command)
                        CMD_TICK: begin
                            if (cur_valid) begin
                                if (expire) begin
                                    if (r_pend) begin
                                        emit          = 1'b1;
                                        emit_res      = r_pend_res;
                                        emit_res.last = 1'b0;
                                    end
                                    n_pend     = 1'b1;
                                    n_pend_res = '{status: ST_EXPIRED,
                                                   out_key: rd_info.key,
                                                   out_elem_type: rd_info.etype,
                                                   out_addr: rd_info.addr,
                                                   out_port: rd_info.port,
                                                   last: 1'b0};
                                    n_valid[r_pidx] = 1'b0;
                                end else begin
                                    st_ctl.ticks_we = 1'b1;
                                    st_ctl.wr_addr  = r_pidx;
                                    wr_ticks = (rd_ticks == TICKS_MAX) ? rd_ticks
                                                                       : rd_ticks + 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (key_hit && !r_found) begin
                                n_found = 1'b1;
                                n_fidx  = r_pidx;
                            end
                            if (!cur_valid && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_pidx;
                            end
                        end
                    endcase
                    if (r_pidx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        st_ctl.rd_en   = 1'b1;
                        st_ctl.rd_addr = r_pidx + 1'b1;
                        n_pidx         = r_pidx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_pend  = 1'b0;
                    case (r_req.command)
                        CMD_TICK: begin
                            emit          = r_pend;
                            emit_res      = r_pend_res;
                            emit_res.last = 1'b1;
                        end
                        CMD_ADD: begin
                            emit = 1'b1;
                            if (r_found) begin
                                st_ctl.ticks_we = 1'b1;
                                st_ctl.wr_addr  = r_fidx;
                                emit_res = make_status(ST_REFRESHED, r_req.link_key);
                            end else if (r_free_found) begin
                                st_ctl.info_we      = 1'b1;
                                st_ctl.ticks_we     = 1'b1;
                                st_ctl.wr_addr      = r_free_idx;
                                n_valid[r_free_idx] = 1'b1;
                                emit_res = make_status(ST_INSERTED, r_req.link_key);
                            end else begin
                                emit_res = make_status(ST_FULL, r_req.link_key);
                            end
                        end
                        default: begin
                            emit = 1'b1;
                            if (r_found) begin
                                n_valid[r_fidx] = 1'b0;
                                emit_res = make_status(ST_REMOVED, r_req.link_key);
                            end else begin
                                emit_res = make_status(ST_NOT_FOUND, r_req.link_key);
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = emit ? 1'b1 : (r_out_valid && i_out_stall);
        n_out       = emit ? emit_res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_pend       <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_pend       <= n_pend;
            r_valid      <= n_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pidx     <= n_pidx;
        r_fidx     <= n_fidx;
        r_free_idx <= n_free_idx;
        r_pend_res <= n_pend_res;
        r_out      <= n_out;
    end

`ifndef SYNTHESIS
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_req.command == CMD_ADD && !r_found && r_free_found)
            |-> !r_valid[r_free_idx])
        else $error("insert target slot already valid");

    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_found) |-> r_valid[r_fidx])
        else $error("matched slot not valid");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_req.command != CMD_TICK && out_free)
            |=> (o_out_valid && o_out_data.last))
        else $error("add/remove finished without a final result");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("expiry left pending at idle");
`endif

endmodule

// ===== tb/sv/keepalive_timeout_table_core_test.sv =====
// ----------------------------------------------------------------------------
// keepalive_timeout_table_core_test
// Self-checking bench for the link aging table: a directed opening (empty tick,
// insert, refresh, remove hit and miss, command 3, fill to full, zero timeout
// flush), then random add/remove/tick traffic over a small key pool under
// several timeout settings. Bursty sender, patterned output stall.
// ----------------------------------------------------------------------------
module keepalive_timeout_table_core_test;
    import kat_pkg::*;

    localparam int NKEYS       = 20;
    localparam int PHASE_ITEMS = 48;
    localparam int SETTLE      = 24;
    localparam int TAIL        = 40;
    localparam int IDLE_LIMIT  = 4000;

    class link_aging_board;
        logic [TICKS_W-1:0] timeout;
        bit                 slot_used[TABLE_DEPTH];
        t_info              slot_info[TABLE_DEPTH];
        logic [TICKS_W-1:0] slot_ticks[TABLE_DEPTH];
        t_out_item          expected_results[$];
        int                 errors;

        function new();
            timeout = TIMEOUT_RESET;
            errors  = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function int find_slot(logic [31:0] key);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && slot_info[i].key == key) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        function void note_request(t_in_item req);
            t_out_item held;
            t_out_item res;
            bit        have_held;
            int        s;
            have_held = 1'b0;
            held      = '0;
            case (req.command)
                CMD_TICK: begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!slot_used[i]) continue;
                        if (slot_ticks[i] >= timeout) begin
                            res               = '0;
                            res.status        = ST_EXPIRED;
                            res.out_key       = slot_info[i].key;
                            res.out_elem_type = slot_info[i].etype;
                            res.out_addr      = slot_info[i].addr;
                            res.out_port      = slot_info[i].port;
                            if (have_held) expected_results = {expected_results, held};
                            held         = res;
                            have_held    = 1'b1;
                            slot_used[i] = 1'b0;
                        end else if (slot_ticks[i] != TICKS_MAX) begin
                            slot_ticks[i]++;
                        end
                    end
                end
                CMD_ADD: begin
                    have_held    = 1'b1;
                    held.out_key = req.link_key;
                    s = find_slot(req.link_key);
                    if (s >= 0) begin
                        slot_ticks[s] = '0;
                        held.status   = ST_REFRESHED;
                    end else begin
                        s = free_slot();
                        if (s >= 0) begin
                            slot_used[s]       = 1'b1;
                            slot_info[s].key   = req.link_key;
                            slot_info[s].etype = req.elem_type;
                            slot_info[s].addr  = req.peer_addr;
                            slot_info[s].port  = req.peer_port;
                            slot_ticks[s]      = '0;
                            held.status        = ST_INSERTED;
                        end else begin
                            held.status = ST_FULL;
                        end
                    end
                end
                CMD_REMOVE: begin
                    have_held    = 1'b1;
                    held.out_key = req.link_key;
                    s = find_slot(req.link_key);
                    if (s >= 0) begin
                        slot_used[s] = 1'b0;
                        held.status  = ST_REMOVED;
                    end else begin
                        held.status = ST_NOT_FOUND;
                    end
                end
                default: ;
            endcase
            if (have_held) begin
                held.last = 1'b1;
                expected_results = {expected_results, held};
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            string     want_s;
            string     got_s;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result: st=%0d key=%h last=%b",
                                     got.status, got.out_key, got.last));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.out_key !== want.out_key ||
                got.out_elem_type !== want.out_elem_type ||
                got.out_addr !== want.out_addr || got.out_port !== want.out_port ||
                got.last !== want.last) begin
                want_s = $sformatf("st=%0d key=%h type=%h addr=%h port=%h last=%b",
                                   want.status, want.out_key, want.out_elem_type,
                                   want.out_addr, want.out_port, want.last);
                got_s  = $sformatf("st=%0d key=%h type=%h addr=%h port=%h last=%b",
                                   got.status, got.out_key, got.out_elem_type,
                                   got.out_addr, got.out_port, got.last);
                flag_error({"mismatch: expected ", want_s, ", got ", got_s});
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    link_aging_board sb = new();
    int              idle_cycles = 0;
    int              cyc = 0;
    int              burst_left = 4;
    int              max_gap = 3;
    logic [31:0]     key_pool[NKEYS];

    keepalive_timeout_table_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic stall_pattern(int c);
        case ((c / 150) % 4)
            0:       return 1'b0;
            1:       return 1'($urandom_range(0, 1));
            2:       return (c % 7) < 3;
            default: return (c % 41) < 17;
        endcase
    endfunction

    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                sb.note_request(in_data);
                moved = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                sb.check_result(o_out_data);
                moved = 1'b1;
            end
        end
        cyc         <= cyc + 1;
        out_stall   <= stall_pattern(cyc);
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_in_item make_request(logic [1:0] cmd, logic [31:0] key,
                                              logic [7:0] etype, logic [31:0] addr,
                                              logic [15:0] port);
        t_in_item r;
        r.command   = cmd;
        r.link_key  = key;
        r.elem_type = etype;
        r.peer_addr = addr;
        r.peer_port = port;
        return r;
    endfunction

    function automatic t_in_item random_request();
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 34)      cmd = CMD_TICK;
        else if (pick < 68) cmd = CMD_ADD;
        else if (pick < 94) cmd = CMD_REMOVE;
        else                cmd = CMD_NONE;
        key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, NKEYS - 1)];
        return make_request(cmd, key, 8'($urandom), $urandom, 16'($urandom));
    endfunction

    task automatic send_request(input t_in_item r, input bit stop);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        if (stop) begin
            in_valid <= 1'b0;
        end else begin
            burst_left--;
            if (burst_left <= 0 && max_gap > 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    // caller must have lowered in_valid
    task automatic wait_for_results(input int extra);
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TICKS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMEOUT, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.timeout = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[TICKS_W-1:0] !== value)
            sb.flag_error($sformatf("timeout readback: expected %0d, got %0d",
                                    value, prdata[TICKS_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [TICKS_W-1:0] phase_timeout[6];
        bit                 pause;
        phase_timeout = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd10};
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < NKEYS; i++) key_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset timeout value in force
        send_request(make_request(CMD_TICK, '0, '0, '0, '0), 1'b0);
        send_request(make_request(CMD_REMOVE, '0, '0, '0, '0), 1'b0);
        send_request(make_request(CMD_ADD, '0, '0, '0, '0), 1'b0);
        send_request(make_request(CMD_ADD, '1, '1, '1, '1), 1'b0);
        send_request(make_request(CMD_ADD, '0, '1, '1, '1), 1'b0);
        send_request(make_request(CMD_NONE, '1, '1, '1, '1), 1'b0);
        send_request(make_request(CMD_REMOVE, '0, '1, '1, '1), 1'b0);
        send_request(make_request(CMD_REMOVE, '0, '0, '0, '0), 1'b0);
        for (int i = 2; i < 17; i++)
            send_request(make_request(CMD_ADD, key_pool[i], 8'($urandom), $urandom,
                                      16'($urandom)), 1'b0);
        send_request(make_request(CMD_ADD, key_pool[17], '1, '1, '1), 1'b1);
        wait_for_results(SETTLE);
        // zero timeout flushes the full table in one tick
        write_timeout(8'd0);
        send_request(make_request(CMD_TICK, '1, '1, '1, '1), 1'b1);
        wait_for_results(SETTLE);

        foreach (phase_timeout[p]) begin
            write_timeout(phase_timeout[p]);
            max_gap    = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
            burst_left = $urandom_range(1, 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pause = (n == PHASE_ITEMS - 1) || ($urandom_range(0, 24) == 0);
                send_request(random_request(), pause);
                if (pause) wait_for_results(SETTLE);
            end
        end

        wait_for_results(TAIL);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kat_pkg.sv
rtl/core/kat_entry_store.sv
rtl/core/keepalive_timeout_table_core.sv
tb/sv/keepalive_timeout_table_core_test.sv
